/* rtl/spi_pkg.sv */
// Package: shared types, register indexes and helpers for the speed PI block.
`default_nettype none
package spi_pkg;

  localparam int unsigned GAIN_W   = 31;
  localparam int unsigned LIMIT_W  = 14;
  localparam int unsigned SPEED_W  = 31;
  localparam int unsigned ERR_W    = 32;
  localparam int unsigned MAG_W    = 31;
  localparam int unsigned PROD_W   = GAIN_W + MAG_W;
  localparam int unsigned Q15_SH   = 15;
  localparam int unsigned TERM_W   = 18;
  localparam int unsigned STATE_W  = 15;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned IN_DW    = 64;
  localparam int unsigned OUT_DW   = 64;

  localparam logic [CFG_AW-1:0] CFG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_INTEG_GAIN = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_LIMIT      = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd10000;
  localparam logic [PROD_W:0]    ROUND_HALF  = 63'd16384;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  // error stage word
  typedef struct packed {
    cmd_t                    cmd;
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic signed [ERR_W-1:0] err;
  } err_word_t;

  // raw product word
  typedef struct packed {
    cmd_t                    cmd;
    logic                    neg;
    logic signed [ERR_W-1:0] err;
    logic [PROD_W-1:0]       p_prod;
    logic [PROD_W-1:0]       i_prod;
  } prod_word_t;

  // rounded, saturated term magnitudes
  typedef struct packed {
    cmd_t                    cmd;
    logic                    neg;
    logic signed [ERR_W-1:0] err;
    logic [TERM_W-1:0]       p_mag;
    logic [TERM_W-1:0]       i_mag;
  } term_word_t;

  typedef struct packed {
    logic [1:0]                pad;
    logic signed [STATE_W-1:0] drive_command;
    logic signed [STATE_W-1:0] integrator_value;
    logic signed [ERR_W-1:0]   speed_error;
  } result_t;

  // Round half away from zero on a magnitude, then saturate at 2^17.
  // Any term that large is beyond every limit, so the sign alone decides.
  function automatic logic [TERM_W-1:0] round_sat(input logic [PROD_W-1:0] prod);
    logic [PROD_W:0]          sum;
    logic [PROD_W-Q15_SH:0]   q;
    sum = {1'b0, prod} + ROUND_HALF;
    q   = sum[PROD_W:Q15_SH];
    if (|q[PROD_W-Q15_SH:TERM_W-1]) begin
      round_sat = {1'b1, {(TERM_W-1){1'b0}}};
    end else begin
      round_sat = q[TERM_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/spi_err_stage.sv */
// Error stage: registers target minus measured, with its sign and magnitude.
`default_nettype none
module spi_err_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire spi_pkg::cmd_t               cmd_i,
  input  wire logic [spi_pkg::SPEED_W-1:0] target_i,
  input  wire logic [spi_pkg::SPEED_W-1:0] measured_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output spi_pkg::err_word_t               word_o
);

  logic               valid_r;
  spi_pkg::err_word_t word_r, word_nxt;
  logic signed [spi_pkg::ERR_W-1:0] err;
  logic        [spi_pkg::ERR_W-1:0] neg_err;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    err      = spi_pkg::ERR_W'($signed(target_i)) - spi_pkg::ERR_W'($signed(measured_i));
    neg_err  = -err;
    word_nxt.cmd = cmd_i;
    word_nxt.err = err;
    word_nxt.neg = err[spi_pkg::ERR_W-1];
    word_nxt.mag = err[spi_pkg::ERR_W-1] ? neg_err[spi_pkg::MAG_W-1:0]
                                         : err[spi_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule
`default_nettype wire

/* rtl/spi_mul_stage.sv */
// Multiply stage: gain products, then Q15 rounding and saturation.
`default_nettype none
module spi_mul_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [spi_pkg::GAIN_W-1:0]  prop_gain_i,
  input  wire logic [spi_pkg::GAIN_W-1:0]  integ_gain_i,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire spi_pkg::err_word_t          word_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output spi_pkg::term_word_t              word_o
);

  logic                valid_a_r, valid_b_r;
  logic                ready_a, ready_b;
  spi_pkg::prod_word_t prod_r, prod_nxt;
  spi_pkg::term_word_t term_r, term_nxt;

  assign ready_b = !valid_b_r || ready_i;
  assign ready_a = !valid_a_r || ready_b;
  assign ready_o = ready_a;

  always_comb begin
    prod_nxt.cmd    = word_i.cmd;
    prod_nxt.neg    = word_i.neg;
    prod_nxt.err    = word_i.err;
    prod_nxt.p_prod = spi_pkg::PROD_W'(prop_gain_i) * spi_pkg::PROD_W'(word_i.mag);
    prod_nxt.i_prod = spi_pkg::PROD_W'(integ_gain_i) * spi_pkg::PROD_W'(word_i.mag);
  end

  always_comb begin
    term_nxt.cmd   = prod_r.cmd;
    term_nxt.neg   = prod_r.neg;
    term_nxt.err   = prod_r.err;
    term_nxt.p_mag = spi_pkg::round_sat(prod_r.p_prod);
    term_nxt.i_mag = spi_pkg::round_sat(prod_r.i_prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_r <= valid_i;
      end
      if (ready_b) begin
        valid_b_r <= valid_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && valid_i) begin
      prod_r <= prod_nxt;
    end
    if (ready_b && valid_a_r) begin
      term_r <= term_nxt;
    end
  end

  assign valid_o = valid_b_r;
  assign word_o  = term_r;

endmodule
`default_nettype wire

/* rtl/spi_acc_stage.sv */
// Integrator stage: conditional integration, clamping and result register.
`default_nettype none
module spi_acc_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [spi_pkg::LIMIT_W-1:0] limit_i,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire spi_pkg::term_word_t         word_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output spi_pkg::result_t                 result_o
);

  localparam int unsigned SW = spi_pkg::TERM_W + 1;
  localparam int unsigned CW = SW + 1;
  localparam int unsigned OW = CW + 1;

  logic                                valid_r;
  logic signed [spi_pkg::STATE_W-1:0]  integ_r, integ_nxt;
  spi_pkg::result_t                    result_r, result_nxt;

  logic signed [SW-1:0] p_s, i_s;
  logic signed [CW-1:0] cand, cand_sel, integ_x, lim_c;
  logic signed [OW-1:0] outv, outv_sel, lim_o;
  logic                 pos, hold;
  logic signed [CW-1:0] integ_clamp;
  logic signed [OW-1:0] out_clamp;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    p_s      = word_i.neg ? -$signed({1'b0, word_i.p_mag}) : $signed({1'b0, word_i.p_mag});
    i_s      = word_i.neg ? -$signed({1'b0, word_i.i_mag}) : $signed({1'b0, word_i.i_mag});
    integ_x  = CW'(integ_r);
    lim_c    = $signed(CW'(limit_i));
    lim_o    = $signed(OW'(limit_i));
    cand     = integ_x + CW'(i_s);
    outv     = OW'(p_s) + OW'(cand);
    pos      = !word_i.neg && (word_i.err != '0);
    hold     = (pos && (outv > lim_o)) || (word_i.neg && (outv < -lim_o));
    cand_sel = hold ? integ_x : cand;
    outv_sel = OW'(p_s) + OW'(cand_sel);

    if (cand_sel > lim_c) begin
      integ_clamp = lim_c;
    end else if (cand_sel < -lim_c) begin
      integ_clamp = -lim_c;
    end else begin
      integ_clamp = cand_sel;
    end

    if (outv_sel > lim_o) begin
      out_clamp = lim_o;
    end else if (outv_sel < -lim_o) begin
      out_clamp = -lim_o;
    end else begin
      out_clamp = outv_sel;
    end

    result_nxt.pad = '0;
    if (word_i.cmd == spi_pkg::CMD_CLEAR) begin
      integ_nxt                   = '0;
      result_nxt.speed_error      = '0;
      result_nxt.integrator_value = '0;
      result_nxt.drive_command    = '0;
    end else begin
      integ_nxt                   = integ_clamp[spi_pkg::STATE_W-1:0];
      result_nxt.speed_error      = word_i.err;
      result_nxt.integrator_value = integ_clamp[spi_pkg::STATE_W-1:0];
      result_nxt.drive_command    = out_clamp[spi_pkg::STATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      integ_r <= '0;
    end else if (ready_o) begin
      valid_r <= valid_i;
      if (valid_i) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      result_r <= result_nxt;
    end
  end

  assign valid_o  = valid_r;
  assign result_o = result_r;

endmodule
`default_nettype wire

/* rtl/speed_pi_conditional_integration.sv */
// Top level: speed PI controller with conditional-integration anti-windup.
//
//  channel | dir | fields (low bit up)
//  in_     | in  | tuser: cmd; tdata: target_speed[30:0], measured_speed[61:31]
//  out_    | out | tdata: speed_error[31:0], integrator_value[46:32],
//          |     |        drive_command[61:47]
//  cfg_    | in  | addr 0 prop_gain, 1 integ_gain_per_period, 2 symmetric limit
//
// One word per cycle while out_tready stays high; four register stages lie between
// the input accept and out_tvalid.
// Stages: error subtract, gain multiply, Q15 round, integrator update.
// The integrator loop closes within the last stage, so words follow back to back.
// Reset clears all valid flags and the integrator, and restores register defaults.
// A stalled output holds each stage in place; in_tready drops once the pipe is full.
`default_nettype none
module speed_pi_conditional_integration (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [spi_pkg::IN_DW-1:0]     in_tdata,  // target_speed, measured_speed
  input  wire logic                          in_tuser,  // cmd
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [spi_pkg::OUT_DW-1:0]         out_tdata, // speed_error, integrator_value,
                                                        // drive_command
  input  wire logic                          cfg_we,
  input  wire logic [spi_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [spi_pkg::GAIN_W-1:0]    cfg_wdata
);

  logic [spi_pkg::GAIN_W-1:0]  prop_gain_r;
  logic [spi_pkg::GAIN_W-1:0]  integ_gain_r;
  logic [spi_pkg::LIMIT_W-1:0] limit_r;

  logic                err_valid, err_ready;
  spi_pkg::err_word_t  err_word;
  logic                term_valid, term_ready;
  spi_pkg::term_word_t term_word;
  spi_pkg::result_t    result;
  spi_pkg::cmd_t       in_cmd;

  assign in_cmd = spi_pkg::cmd_t'(in_tuser);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      limit_r      <= spi_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        spi_pkg::CFG_PROP_GAIN:  prop_gain_r  <= cfg_wdata;
        spi_pkg::CFG_INTEG_GAIN: integ_gain_r <= cfg_wdata;
        spi_pkg::CFG_LIMIT:      limit_r      <= cfg_wdata[spi_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  spi_err_stage u_err (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (in_tvalid),
    .ready_o    (in_tready),
    .cmd_i      (in_cmd),
    .target_i   (in_tdata[spi_pkg::SPEED_W-1:0]),
    .measured_i (in_tdata[2*spi_pkg::SPEED_W-1:spi_pkg::SPEED_W]),
    .valid_o    (err_valid),
    .ready_i    (err_ready),
    .word_o     (err_word)
  );

  spi_mul_stage u_mul (
    .clk          (clk),
    .rst_n        (rst_n),
    .prop_gain_i  (prop_gain_r),
    .integ_gain_i (integ_gain_r),
    .valid_i      (err_valid),
    .ready_o      (err_ready),
    .word_i       (err_word),
    .valid_o      (term_valid),
    .ready_i      (term_ready),
    .word_o       (term_word)
  );

  spi_acc_stage u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .limit_i  (limit_r),
    .valid_i  (term_valid),
    .ready_o  (term_ready),
    .word_i   (term_word),
    .valid_o  (out_tvalid),
    .ready_i  (out_tready),
    .result_o (result)
  );

  assign out_tdata = result;

endmodule
`default_nettype wire
